>>> hdl/cuckoo_hash_table_assert.svh
// ----------------------------------------------------------------------------
// Cuckoo hash table assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CUCKOO_HASH_TABLE_ASSERT_SVH
`define CUCKOO_HASH_TABLE_ASSERT_SVH

// same-cycle implication
`define CKH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CKH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ckh_pkg.sv
// ----------------------------------------------------------------------------
// Cuckoo hash table package
// Word types, status codes and shared constants.
// ----------------------------------------------------------------------------
package ckh_pkg;

    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int CNT_W      = 12;
    localparam int KICK_W     = 12;
    localparam int STAT_W     = 3;
    localparam int SLOTS_DEF  = 1024;

    localparam logic [KEY_W-1:0]  FIB_FRAC    = 32'd2654431523;
    localparam logic [KICK_W-1:0] KICKS_RESET = 12'd2058;

    localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd3;
    localparam logic [STAT_W-1:0] ST_FAILED   = 3'd4;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [KEY_W-1:0]        leftover_key;
        logic signed [VAL_W-1:0] leftover_value;
        logic [CNT_W-1:0]        entry_count;
    } rsp_t;

    typedef struct packed {
        logic                    valid;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } slot_t;

endpackage

>>> hdl/cuckoo_hash_table.sv
// ----------------------------------------------------------------------------
// Cuckoo hash table
// A two-table cuckoo map of 32-bit keys to 32-bit values. A request word is
// taken when start is high and busy low; its result word appears on rsp for
// exactly one cycle with done high and must be taken then, as it cannot be
// held off. After reset both tables are swept clear, one slot a cycle, over
// all SLOTS slots (1024 by default) with busy high. A remove, or an insert
// that finds its key (an update), runs the shared index unit (with a longer
// reciprocal remainder when SLOTS is not a power of two), reads both tables,
// takes one decision and returns to idle, where the next word is taken. An
// insert into a free first slot adds one write. Each eviction round adds two
// index runs and two table writes.
// ----------------------------------------------------------------------------
module cuckoo_hash_table
    import ckh_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  req_t              req,
    input  logic              wr_en,
    input  logic [KICK_W-1:0] wr_data,
    output logic              done,
    output rsp_t              rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(SLOTS - 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_HASH  = 8'b0000_0100,
        S_LOOK  = 8'b0000_1000,
        S_KICK1 = 8'b0001_0000,
        S_WAIT2 = 8'b0010_0000,
        S_KICK2 = 8'b0100_0000,
        S_WAIT1 = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [KICK_W-1:0]   kicks_reg, kicks_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [KICK_W-1:0]   round_reg, round_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic                done_reg, done_next;
    rsp_t                rsp_reg, rsp_next;
    logic                kind_reg, kind_next;
    logic [KEY_W-1:0]    ck_reg, ck_next;
    logic signed [VAL_W-1:0] cv_reg, cv_next;
    logic [IDX_W-1:0]    a_reg, a_next;
    logic [IDX_W-1:0]    b_reg, b_next;

    slot_t               mem1 [SLOTS];
    slot_t               mem2 [SLOTS];
    slot_t               rd1_reg;
    slot_t               rd2_reg;

    logic                we1, we2, re1, re2;
    logic [IDX_W-1:0]    wa1, wa2, ra1, ra2;
    slot_t               wd1, wd2;

    logic                hs_start;
    logic [KEY_W-1:0]    hs_key;
    logic                h_done;
    logic [IDX_W-1:0]    h_idx1, h_idx2;

    logic                hit1, hit2;
    logic                fin;
    logic [STAT_W-1:0]   fin_status;
    logic [KEY_W-1:0]    fin_lk;
    logic signed [VAL_W-1:0] fin_lv;

    ckh_hash #(
        .SLOTS (SLOTS)
    ) u_ckh_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hs_start),
        .key   (hs_key),
        .done  (h_done),
        .idx1  (h_idx1),
        .idx2  (h_idx2)
    );

    assign hit1 = rd1_reg.valid && (rd1_reg.key == ck_reg);
    assign hit2 = rd2_reg.valid && (rd2_reg.key == ck_reg);

    always_comb
    begin
        state_next = state_reg;
        kicks_next = wr_en ? wr_data : kicks_reg;
        count_next = count_reg;
        round_next = round_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        kind_next  = kind_reg;
        ck_next    = ck_reg;
        cv_next    = cv_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        we1        = 1'b0;
        we2        = 1'b0;
        wa1        = a_reg;
        wa2        = b_reg;
        wd1        = '{valid: 1'b1, key: ck_reg, value: cv_reg};
        wd2        = '{valid: 1'b1, key: ck_reg, value: cv_reg};
        re1        = 1'b0;
        re2        = 1'b0;
        ra1        = h_idx1;
        ra2        = h_idx2;
        hs_start   = 1'b0;
        hs_key     = req.key;
        fin        = 1'b0;
        fin_status = ST_ABSENT;
        fin_lk     = '0;
        fin_lv     = '0;

        case (state_reg)
            S_CLEAR:
            begin
                we1 = 1'b1;
                we2 = 1'b1;
                wa1 = clr_reg;
                wa2 = clr_reg;
                wd1 = '0;
                wd2 = '0;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = req.req_type;
                    ck_next    = req.key;
                    cv_next    = req.value;
                    hs_start   = 1'b1;
                    state_next = S_HASH;
                end
            end

            S_HASH:
            begin
                if (h_done)
                begin
                    re1        = 1'b1;
                    re2        = 1'b1;
                    a_next     = h_idx1;
                    b_next     = h_idx2;
                    state_next = S_LOOK;
                end
            end

            S_LOOK:
            begin
                if (kind_reg == REQ_REMOVE)
                begin
                    fin = 1'b1;
                    if (hit1)
                    begin
                        we1        = 1'b1;
                        wd1        = '0;
                        count_next = count_reg - 1'b1;
                        fin_status = ST_REMOVED;
                    end
                    else if (hit2)
                    begin
                        we2        = 1'b1;
                        wd2        = '0;
                        count_next = count_reg - 1'b1;
                        fin_status = ST_REMOVED;
                    end
                    else
                    begin
                        fin_status = ST_ABSENT;
                    end
                end
                else if (hit1)
                begin
                    we1        = 1'b1;
                    fin        = 1'b1;
                    fin_status = ST_UPDATED;
                end
                else if (hit2)
                begin
                    we2        = 1'b1;
                    fin        = 1'b1;
                    fin_status = ST_UPDATED;
                end
                else if (kicks_reg == '0)
                begin
                    fin        = 1'b1;
                    fin_status = ST_FAILED;
                    fin_lk     = ck_reg;
                    fin_lv     = cv_reg;
                end
                else
                begin
                    round_next = '0;
                    state_next = S_KICK1;
                end
            end

            S_KICK1:
            begin
                we1 = 1'b1;
                if (!rd1_reg.valid)
                begin
                    count_next = count_reg + 1'b1;
                    fin        = 1'b1;
                    fin_status = ST_INSERTED;
                end
                else
                begin
                    ck_next    = rd1_reg.key;
                    cv_next    = rd1_reg.value;
                    hs_start   = 1'b1;
                    hs_key     = rd1_reg.key;
                    state_next = S_WAIT2;
                end
            end

            S_WAIT2:
            begin
                if (h_done)
                begin
                    re2        = 1'b1;
                    b_next     = h_idx2;
                    state_next = S_KICK2;
                end
            end

            S_KICK2:
            begin
                we2 = 1'b1;
                if (!rd2_reg.valid)
                begin
                    count_next = count_reg + 1'b1;
                    fin        = 1'b1;
                    fin_status = ST_INSERTED;
                end
                else
                begin
                    ck_next = rd2_reg.key;
                    cv_next = rd2_reg.value;
                    if ((round_reg + 1'b1) == kicks_reg)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_FAILED;
                        fin_lk     = rd2_reg.key;
                        fin_lv     = rd2_reg.value;
                    end
                    else
                    begin
                        round_next = round_reg + 1'b1;
                        hs_start   = 1'b1;
                        hs_key     = rd2_reg.key;
                        state_next = S_WAIT1;
                    end
                end
            end

            S_WAIT1:
            begin
                if (h_done)
                begin
                    re1        = 1'b1;
                    a_next     = h_idx1;
                    state_next = S_KICK1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            done_next  = 1'b1;
            rsp_next   = '{status: fin_status, leftover_key: fin_lk,
                           leftover_value: fin_lv, entry_count: count_next};
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            kicks_reg <= KICKS_RESET;
            count_reg <= '0;
            round_reg <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            kind_reg  <= REQ_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            kicks_reg <= kicks_next;
            count_reg <= count_next;
            round_reg <= round_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            kind_reg  <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        ck_reg  <= ck_next;
        cv_reg  <= cv_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            mem1[wa1] <= wd1;
        end
        if (re1)
        begin
            rd1_reg <= mem1[ra1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we2)
        begin
            mem2[wa2] <= wd2;
        end
        if (re2)
        begin
            rd2_reg <= mem2[ra2];
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> hdl/ckh_hash.sv
// ----------------------------------------------------------------------------
// Cuckoo hash index unit
// Computes both table indexes of a key: the remainder by the slot count through
// a reciprocal multiply, a back-multiply and two compare-subtract steps (a mask
// when the slot count is a power of two), and the multiplicative index through a
// registered multiply.
// ----------------------------------------------------------------------------
module ckh_hash
    import ckh_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [KEY_W-1:0]                       key,
    output logic                                   done,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] idx1,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] idx2
);

    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam bit POW2      = (SLOTS & (SLOTS - 1)) == 0;
    localparam int SCNT_W    = 2;
    localparam int LAST      = POW2 ? 1 : 2;
    localparam int REM_W     = IDX_W + 2;

    localparam logic [IDX_W:0]    SLOTS_W  = (IDX_W + 1)'(SLOTS);
    localparam logic [REM_W-1:0]  SLOTS_R  = REM_W'(SLOTS);
    localparam logic [KEY_W-1:0]  SLOTS_K  = KEY_W'(SLOTS);
    localparam logic [KEY_W-1:0]  RECIP    = KEY_W'((64'd1 << KEY_W) / SLOTS);
    localparam logic [SCNT_W-1:0] LAST_CNT = SCNT_W'(LAST);

    logic                    busy_reg, busy_next;
    logic [SCNT_W-1:0]       cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    logic [KEY_W-1:0]        key_reg;
    logic [KEY_W-1:0]        frac_reg;
    logic [KEY_W-1:0]        quot_reg;
    logic [REM_W-1:0]        rest_reg;
    logic [IDX_W-1:0]        rem_reg;
    logic [IDX_W-1:0]        idx2_reg;
    logic [IDX_W-1:0]        rem_fix;
    logic [KEY_W-1:0]        frac_in;
    logic [2*KEY_W-1:0]      quot_prod;
    logic [KEY_W-1:0]        rest_full;
    logic [KEY_W+IDX_W:0]    prod;

    assign quot_prod = {{KEY_W{1'b0}}, key_reg} * {{KEY_W{1'b0}}, RECIP};
    assign rest_full = key_reg - quot_reg * SLOTS_K;

    always_comb
    begin
        logic [REM_W-1:0] r;
        r = rest_reg;
        if (r >= SLOTS_R)
        begin
            r = r - SLOTS_R;
        end
        if (r >= SLOTS_R)
        begin
            r = r - SLOTS_R;
        end
        rem_fix = r[IDX_W-1:0];
    end

    assign frac_in = key * FIB_FRAC;
    assign prod    = {{(IDX_W + 1){1'b0}}, frac_reg} * {{KEY_W{1'b0}}, SLOTS_W};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = busy_reg && (cnt_reg == LAST_CNT);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_CNT)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg  <= key;
            frac_reg <= frac_in;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_prod[2*KEY_W-1:KEY_W];
            rest_reg <= rest_full[REM_W-1:0];
            rem_reg  <= rem_fix;
            idx2_reg <= prod[KEY_W +: IDX_W];
        end
    end

    assign done = done_reg;
    assign idx1 = POW2 ? key_reg[IDX_W-1:0] : rem_reg;
    assign idx2 = idx2_reg;

endmodule

>>> hdl/ckh_checker.sv
// ----------------------------------------------------------------------------
// Cuckoo hash table port checker
// Watches the top-level ports for request and result ordering, status codes and leftovers.
// ----------------------------------------------------------------------------
`include "cuckoo_hash_table_assert.svh"

module ckh_checker
    import ckh_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    `CKH_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "no busy after accept")
    `CKH_ASSERT_NEXT(a_single_done, done, !done, "result word repeated")
    `CKH_ASSERT_NOW(a_status_range, done, rsp.status <= ST_FAILED, "status code out of range")
    `CKH_ASSERT_NOW(a_leftover_clear, done && (rsp.status != ST_FAILED), (rsp.leftover_key == '0) && (rsp.leftover_value == '0), "leftover set without failure")

endmodule

bind cuckoo_hash_table ckh_checker u_ckh_checker (.*);

>>> dv/cuckoo_hash_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cuckoo hash table testbench
// Drives insert, update and remove words into the two-table map and checks
// every result word against a shadow copy of both tables. Directed words hit
// the key and value extremes, first and second table hits, kick chains, a
// zero kick budget and failed inserts on keys that share both slots. Random
// bursts then run under several kick budgets, the sender idling between most
// bursts and draining fully before each register write.
// ----------------------------------------------------------------------------
module cuckoo_hash_table_tb;
    import ckh_pkg::*;

    localparam int SLOTS       = SLOTS_DEF;
    localparam int GROUPS      = 4;
    localparam int GROUP_KEYS  = 4;
    localparam int CLUSTERS    = 4;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 92;
    localparam int POOL_MAX    = 64;
    localparam int TAIL_CYCLES = 64;
    localparam int SHOW_MAX    = 10;

    class ckh_shadow_map;
        logic [KEY_W-1:0]  t1_key  [SLOTS];
        logic [VAL_W-1:0]  t1_val  [SLOTS];
        bit                t1_used [SLOTS];
        logic [KEY_W-1:0]  t2_key  [SLOTS];
        logic [VAL_W-1:0]  t2_val  [SLOTS];
        bit                t2_used [SLOTS];
        logic [CNT_W-1:0]  count;
        logic [KICK_W-1:0] kicks;
        rsp_t              expected_rsp [$];
        int                mismatches;

        function new();
            count      = '0;
            kicks      = KICKS_RESET;
            mismatches = 0;
            foreach (t1_used[i])
            begin
                t1_used[i] = 1'b0;
                t2_used[i] = 1'b0;
            end
        endfunction

        static function int unsigned slot_one(logic [KEY_W-1:0] k);
            return k % SLOTS;
        endfunction

        static function int unsigned slot_two(logic [KEY_W-1:0] k);
            logic [31:0] frac;
            logic [63:0] scaled;
            frac   = k * FIB_FRAC;
            scaled = {32'd0, frac} * 64'(SLOTS);
            return scaled[63:32] % SLOTS;
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        function void note_request(req_t r);
            rsp_t             e;
            int unsigned      a;
            int unsigned      b;
            logic [KEY_W-1:0] ck;
            logic [KEY_W-1:0] tk;
            logic [VAL_W-1:0] cv;
            logic [VAL_W-1:0] tv;
            int               round;
            bit               placed;
            e = '0;
            a = slot_one(r.key);
            b = slot_two(r.key);
            if (r.req_type == REQ_REMOVE)
            begin
                if (t1_used[a] && t1_key[a] == r.key)
                begin
                    t1_used[a] = 1'b0;
                    count      = count - 1'b1;
                    e.status   = ST_REMOVED;
                end
                else if (t2_used[b] && t2_key[b] == r.key)
                begin
                    t2_used[b] = 1'b0;
                    count      = count - 1'b1;
                    e.status   = ST_REMOVED;
                end
                else
                    e.status = ST_ABSENT;
            end
            else if (t1_used[a] && t1_key[a] == r.key)
            begin
                t1_val[a] = r.value;
                e.status  = ST_UPDATED;
            end
            else if (t2_used[b] && t2_key[b] == r.key)
            begin
                t2_val[b] = r.value;
                e.status  = ST_UPDATED;
            end
            else
            begin
                ck     = r.key;
                cv     = r.value;
                placed = 1'b0;
                for (round = 0; round < int'(kicks) && !placed; round++)
                begin
                    a = slot_one(ck);
                    if (!t1_used[a])
                    begin
                        t1_key[a]  = ck;
                        t1_val[a]  = cv;
                        t1_used[a] = 1'b1;
                        placed     = 1'b1;
                    end
                    else
                    begin
                        tk = t1_key[a]; t1_key[a] = ck; ck = tk;
                        tv = t1_val[a]; t1_val[a] = cv; cv = tv;
                        b = slot_two(ck);
                        if (!t2_used[b])
                        begin
                            t2_key[b]  = ck;
                            t2_val[b]  = cv;
                            t2_used[b] = 1'b1;
                            placed     = 1'b1;
                        end
                        else
                        begin
                            tk = t2_key[b]; t2_key[b] = ck; ck = tk;
                            tv = t2_val[b]; t2_val[b] = cv; cv = tv;
                        end
                    end
                end
                if (placed)
                begin
                    count    = count + 1'b1;
                    e.status = ST_INSERTED;
                end
                else
                begin
                    e.status         = ST_FAILED;
                    e.leftover_key   = ck;
                    e.leftover_value = cv;
                end
            end
            e.entry_count = count;
            expected_rsp.push_back(e);
        endfunction

        function void log_mismatch(string what, rsp_t e, rsp_t got);
            mismatches++;
            if (mismatches <= SHOW_MAX)
                $display("%s: exp st=%0d lk=%h lv=%h cnt=%0d, got st=%0d lk=%h lv=%h cnt=%0d",
                         what, e.status, e.leftover_key, e.leftover_value, e.entry_count,
                         got.status, got.leftover_key, got.leftover_value, got.entry_count);
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;
            if (expected_rsp.size() == 0)
            begin
                log_mismatch("unexpected result word", '0, got);
                return;
            end
            e = expected_rsp.pop_front();
            if (got.status !== e.status)
                log_mismatch("status", e, got);
            else if (got.leftover_key !== e.leftover_key)
                log_mismatch("leftover key", e, got);
            else if (got.leftover_value !== e.leftover_value)
                log_mismatch("leftover value", e, got);
            else if (got.entry_count !== e.entry_count)
                log_mismatch("entry count", e, got);
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    req_t              req;
    logic              wr_en;
    logic [KICK_W-1:0] wr_data;
    logic              done;
    rsp_t              rsp;

    ckh_shadow_map     shadow;
    longint            cycle_count = 0;
    longint            cycle_limit = 4 * SLOTS + 2000;
    logic [KEY_W-1:0]  used_keys [$];
    logic [KEY_W-1:0]  group_keys [GROUPS][GROUP_KEYS];
    int unsigned       cluster_slot [CLUSTERS];
    int unsigned       phase_kicks [PHASES] = '{1, 4095, 2, 0, 37, 2058};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    cuckoo_hash_table #(.SLOTS(SLOTS)) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .done    (done),
        .rsp     (rsp)
    );

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            shadow.check_response(rsp);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic req_t make_word(logic kind, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        req_t r;
        r.req_type = kind;
        r.key      = k;
        r.value    = v;
        return r;
    endfunction

    function automatic void build_groups();
        logic [KEY_W-1:0] cand;
        int               g;
        int               n;
        for (g = 0; g < GROUPS; g++)
        begin
            cand             = $urandom;
            group_keys[g][0] = cand;
            n                = 1;
            while (n < GROUP_KEYS)
            begin
                cand = cand + KEY_W'(SLOTS);
                if (ckh_shadow_map::slot_two(cand) == ckh_shadow_map::slot_two(group_keys[g][0]))
                begin
                    group_keys[g][n] = cand;
                    n++;
                end
            end
        end
        for (g = 0; g < CLUSTERS; g++)
            cluster_slot[g] = $urandom_range(SLOTS - 1);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(bit for_remove);
        logic [KEY_W-1:0] k;
        int               sel;
        sel = $urandom_range(99);
        if (used_keys.size() > 0 && sel < (for_remove ? 60 : 30))
            return used_keys[$urandom_range(used_keys.size() - 1)];
        sel = $urandom_range(99);
        k   = $urandom;
        if (sel < 5)
            return group_keys[$urandom_range(GROUPS - 1)][$urandom_range(GROUP_KEYS - 1)];
        if (sel < 45)
            return k - (k % SLOTS) + cluster_slot[$urandom_range(CLUSTERS - 1)];
        if (sel < 50)
            return ($urandom_range(1) == 0) ? '0 : '1;
        return k;
    endfunction

    task automatic send_word(input req_t r);
        cycle_limit += 64 + 24 * (longint'(shadow.kicks) + 1);
        if (r.req_type == REQ_INSERT)
        begin
            used_keys.push_back(r.key);
            if (used_keys.size() > POOL_MAX)
                used_keys.delete($urandom_range(POOL_MAX - 1));
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        shadow.note_request(r);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        cycle_limit += n;
        repeat (n)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        cycle_limit += 16;
        @(posedge clk);
        while (shadow.pending() > 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_kicks(input logic [KICK_W-1:0] v);
        wait_idle();
        wr_en   <= 1'b1;
        wr_data <= v;
        @(posedge clk);
        shadow.kicks = v;
        wr_en <= 1'b0;
    endtask

    task automatic run_random(input int n_items);
        req_t r;
        int   left;
        int   burst;
        int   gap;
        left = n_items;
        while (left > 0)
        begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && left > 0)
            begin
                r.req_type = ($urandom_range(99) < 28) ? REQ_REMOVE : REQ_INSERT;
                r.key      = pick_key(r.req_type == REQ_REMOVE);
                r.value    = pick_value();
                send_word(r);
                burst--;
                left--;
            end
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
                idle_cycles(gap);
        end
    endtask

    initial
    begin
        int p;
        shadow  = new();
        rst_n   <= 1'b0;
        start   <= 1'b0;
        req     <= '0;
        wr_en   <= 1'b0;
        wr_data <= '0;
        build_groups();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        // extremes, both tables, update and remove at the reset budget
        send_word(make_word(REQ_INSERT, 32'h0000_0000, 32'h7FFF_FFFF));
        send_word(make_word(REQ_INSERT, 32'hFFFF_FFFF, 32'h8000_0000));
        send_word(make_word(REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF));
        send_word(make_word(REQ_REMOVE, 32'hFFFF_FFFF, 32'h1234_5678));
        send_word(make_word(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000));
        send_word(make_word(REQ_INSERT, 32'h0000_0000 + SLOTS, 32'h0000_0005));
        send_word(make_word(REQ_INSERT, 32'h0000_0000, 32'h0000_0009));
        send_word(make_word(REQ_REMOVE, 32'h0000_0000, 32'h0000_0000));
        send_word(make_word(REQ_REMOVE, 32'h0000_0000 + SLOTS, 32'h0000_0000));

        // keys sharing both slots: the third one cannot fit
        send_word(make_word(REQ_INSERT, group_keys[0][0], 32'h0000_0010));
        send_word(make_word(REQ_INSERT, group_keys[0][1], 32'h0000_0011));
        send_word(make_word(REQ_INSERT, group_keys[0][2], 32'h0000_0012));
        send_word(make_word(REQ_REMOVE, group_keys[0][1], 32'h0000_0000));
        send_word(make_word(REQ_INSERT, group_keys[0][2], 32'h0000_0013));

        // zero budget: new keys fail at once, present keys still update
        write_kicks('0);
        send_word(make_word(REQ_INSERT, $urandom, 32'h8000_0001));
        send_word(make_word(REQ_INSERT, group_keys[0][0], 32'h0000_0020));
        send_word(make_word(REQ_REMOVE, group_keys[0][0], 32'h0000_0000));

        // single round: short chains and a quick failure
        write_kicks(12'd1);
        send_word(make_word(REQ_INSERT, 32'd7, 32'h0000_0030));
        send_word(make_word(REQ_INSERT, 32'd7 + SLOTS, 32'h0000_0031));
        send_word(make_word(REQ_INSERT, 32'd7 + 2 * SLOTS, 32'h0000_0032));
        send_word(make_word(REQ_INSERT, group_keys[1][0], 32'h0000_0040));
        send_word(make_word(REQ_INSERT, group_keys[1][1], 32'h0000_0041));
        send_word(make_word(REQ_INSERT, group_keys[1][2], 32'h0000_0042));

        // full budget on a cycle that never resolves
        write_kicks(12'd4095);
        send_word(make_word(REQ_INSERT, group_keys[1][3], 32'h0000_0043));

        for (p = 0; p < PHASES; p++)
        begin
            write_kicks(KICK_W'(phase_kicks[p]));
            run_random(PHASE_ITEMS);
        end

        wait_idle();
        idle_cycles(TAIL_CYCLES);
        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> cuckoo_hash_table.f
+incdir+hdl
hdl/ckh_pkg.sv
hdl/ckh_hash.sv
hdl/cuckoo_hash_table.sv
hdl/ckh_checker.sv
dv/cuckoo_hash_table_tb.sv
